[hdl/integer_alu_mul_div_pow_rem_defines.svh]
// ---------------------------------------------------------------------------
// Integer ALU assertion macros
// Shared property macros for the integer ALU checks.
// ---------------------------------------------------------------------------
`ifndef INTEGER_ALU_MUL_DIV_POW_REM_DEFINES_SVH
`define INTEGER_ALU_MUL_DIV_POW_REM_DEFINES_SVH

`define IAMDP_CHECK(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("integer alu check failed");

`define IAMDP_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("integer alu implication failed");

`endif

[hdl/iamdp_pkg.sv]
// ---------------------------------------------------------------------------
// Integer ALU package
// Word width, operation and error codes, and the pipeline stage record.
// ---------------------------------------------------------------------------
`default_nettype none

package iamdp_pkg;

   localparam int WORD_BITS = 32;
   localparam int STEPS     = WORD_BITS;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_POW = 3'd4;
   localparam logic [2:0] OP_REM = 3'd5;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
   localparam logic [1:0] ERR_NEG_EXP  = 2'd2;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] op;
      logic [1:0] err;
      logic       neg;
      word_type   x;
      word_type   y;
      word_type   z;
   } stage_type;

endpackage

`default_nettype wire

[hdl/integer_alu_mul_div_pow_rem.sv]
// ---------------------------------------------------------------------------
// Integer ALU with multiply, divide, power and remainder
// Pipelined signed ALU: one request in, one result out.
// ---------------------------------------------------------------------------
// A request transfers when start is high and busy is low; busy stays low,
// so a request may be issued on every clock cycle. Each request carries an
// operation, a dividend/base and a divisor/exponent.
// Every request yields exactly one result, in request order. A request
// passes through one entry register, one register per division or
// square-and-multiply step (WORD_BITS steps), and the output register,
// which drives rsp_valid with the result; all operations share the same
// latency. Throughput is one request per cycle.
// Division or remainder by zero gives result 0 and error code 1; a negative
// exponent gives result 0 and error code 2.
// Synchronous reset drops every request in flight; no result follows.
// The receiver cannot stall: each result must be taken when strobed.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_alu_mul_div_pow_rem (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire  [2:0]                 req_type,
   input  wire  signed [iamdp_pkg::WORD_BITS-1:0] req_operand_a,
   input  wire  signed [iamdp_pkg::WORD_BITS-1:0] req_operand_b,
   output logic                       rsp_valid,
   output logic signed [iamdp_pkg::WORD_BITS-1:0] rsp_result,
   output logic [1:0]                 rsp_error_code
);
   import iamdp_pkg::*;

   `include "integer_alu_mul_div_pow_rem_defines.svh"

   stage_type  entry_ff;
   stage_type  entry_in;
   stage_type  chain [0:STEPS];
   word_type   a_mag;
   word_type   b_mag;
   logic       sa;
   logic       sb;
   word_type   fin_in;
   logic       valid_ff;
   word_type   result_ff;
   logic [1:0] err_ff;

   assign busy = 1'b0;
   assign sa   = req_operand_a[WORD_BITS-1];
   assign sb   = req_operand_b[WORD_BITS-1];
   assign a_mag = sa ? word_type'(-req_operand_a) : word_type'(req_operand_a);
   assign b_mag = sb ? word_type'(-req_operand_b) : word_type'(req_operand_b);

   always_comb begin
      entry_in.valid = start;
      entry_in.op    = req_type;
      entry_in.err   = ERR_NONE;
      entry_in.neg   = 1'b0;
      entry_in.x     = '0;
      entry_in.y     = '0;
      entry_in.z     = '0;
      unique case (req_type) inside
         OP_ADD: entry_in.y = word_type'(req_operand_a + req_operand_b);
         OP_SUB: entry_in.y = word_type'(req_operand_a - req_operand_b);
         OP_MUL: entry_in.y = word_type'(req_operand_a * req_operand_b);
         OP_DIV, OP_REM: begin
            if (req_operand_b == '0) begin
               entry_in.err = ERR_DIV_ZERO;
            end else begin
               entry_in.x   = a_mag;
               entry_in.z   = b_mag;
               entry_in.neg = (req_type == OP_DIV) ? (sa ^ sb) : sa;
            end
         end
         OP_POW: begin
            if (sb) begin
               entry_in.err = ERR_NEG_EXP;
            end else begin
               entry_in.x = word_type'(req_operand_a);
               entry_in.y = word_type'(1);
               entry_in.z = word_type'(req_operand_b);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign chain[0] = entry_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      iamdp_step u_step (
         .clock   (clock),
         .reset   (reset),
         .stage_i (chain[i]),
         .stage_o (chain[i+1])
      );
   end

   always_comb begin
      fin_in = chain[STEPS].y;
      if (chain[STEPS].err == ERR_NONE) begin
         if (chain[STEPS].op == OP_DIV) begin
            fin_in = chain[STEPS].neg ? word_type'(-chain[STEPS].x) : chain[STEPS].x;
         end else if (chain[STEPS].op == OP_REM) begin
            fin_in = chain[STEPS].neg ? word_type'(-chain[STEPS].y) : chain[STEPS].y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= chain[STEPS].valid;
      end
      result_ff <= fin_in;
      err_ff    <= chain[STEPS].err;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_result     = result_ff;
   assign rsp_error_code = err_ff;

   `IAMDP_IMPLY(a_err_code_range, clock, reset, rsp_valid, rsp_error_code != 2'd3)
   `IAMDP_IMPLY(a_err_zero_result, clock, reset, rsp_valid && rsp_error_code != ERR_NONE, rsp_result == '0)
   `IAMDP_CHECK(a_never_busy, clock, reset, !busy)

endmodule

`default_nettype wire

[hdl/iamdp_step.sv]
// ---------------------------------------------------------------------------
// Integer ALU iteration stage
// One registered step of restoring division or of square-and-multiply.
// ---------------------------------------------------------------------------
`default_nettype none

module iamdp_step (
   input  wire                  clock,
   input  wire                  reset,
   input  iamdp_pkg::stage_type stage_i,
   output iamdp_pkg::stage_type stage_o
);
   import iamdp_pkg::*;

   stage_type                stage_ff;
   stage_type                stage_in;
   logic [WORD_BITS:0]       rem_sh;
   logic [WORD_BITS:0]       diff;
   logic                     active;

   assign active = (stage_i.err == ERR_NONE);
   assign rem_sh = {stage_i.y, stage_i.x[WORD_BITS-1]};
   assign diff   = rem_sh - {1'b0, stage_i.z};

   always_comb begin
      stage_in = stage_i;
      if (active && (stage_i.op == OP_DIV || stage_i.op == OP_REM)) begin
         if (!diff[WORD_BITS]) begin
            stage_in.y = diff[WORD_BITS-1:0];
            stage_in.x = {stage_i.x[WORD_BITS-2:0], 1'b1};
         end else begin
            stage_in.y = rem_sh[WORD_BITS-1:0];
            stage_in.x = {stage_i.x[WORD_BITS-2:0], 1'b0};
         end
      end else if (active && stage_i.op == OP_POW) begin
         if (stage_i.z[0]) begin
            stage_in.y = word_type'(stage_i.y * stage_i.x);
         end
         stage_in.x = word_type'(stage_i.x * stage_i.x);
         stage_in.z = {1'b0, stage_i.z[WORD_BITS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

`default_nettype wire

[verif/tb_integer_alu_mul_div_pow_rem.sv]
// ---------------------------------------------------------------------------
// Integer ALU testbench
// Drives add, subtract, multiply, divide, power and remainder requests
// through the command interface in bursts with random gaps. It predicts each
// result and error code, queues the prediction, and checks the strobed
// results against the queue in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_integer_alu_mul_div_pow_rem;
   timeunit 1ns;
   timeprecision 1ps;

   import iamdp_pkg::*;

   typedef struct packed {
      logic [2:0] op;
      word_type   a;
      word_type   b;
      logic       known;
      word_type   res;
      logic [1:0] err;
   } row_type;

   typedef struct packed {
      word_type   res;
      logic [1:0] err;
   } answer_type;

   localparam word_type MIN_W = 32'h8000_0000;
   localparam word_type MAX_W = 32'h7fff_ffff;
   localparam word_type ONES  = 32'hffff_ffff;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [2:0] req_type;
   logic signed [WORD_BITS-1:0] req_operand_a;
   logic signed [WORD_BITS-1:0] req_operand_b;
   logic rsp_valid;
   logic signed [WORD_BITS-1:0] rsp_result;
   logic [1:0] rsp_error_code;

   answer_type pending[$];
   int errors;
   int results_seen;
   int sent;
   row_type directed[$];

   integer_alu_mul_div_pow_rem u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .rsp_valid(rsp_valid),
      .rsp_result(rsp_result), .rsp_error_code(rsp_error_code)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic word_type abs_w(word_type v);
      return v[WORD_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic answer_type alu_answer(logic [2:0] op, word_type a, word_type b);
      answer_type r;
      word_type acc;
      word_type sq;
      word_type q;
      r.res = '0;
      r.err = ERR_NONE;
      case (op) inside
         OP_ADD: r.res = a + b;
         OP_SUB: r.res = a - b;
         OP_MUL: r.res = a * b;
         OP_DIV, OP_REM: begin
            if (b == '0) begin
               r.err = ERR_DIV_ZERO;
            end else if (op == OP_DIV) begin
               q = abs_w(a) / abs_w(b);
               r.res = (a[WORD_BITS-1] ^ b[WORD_BITS-1]) ? (~q + 1'b1) : q;
            end else begin
               q = abs_w(a) % abs_w(b);
               r.res = a[WORD_BITS-1] ? (~q + 1'b1) : q;
            end
         end
         OP_POW: begin
            if (b[WORD_BITS-1]) begin
               r.err = ERR_NEG_EXP;
            end else begin
               acc = 1;
               sq = a;
               for (int i = 0; i < WORD_BITS; i++) begin
                  if (b[i]) acc = acc * sq;
                  sq = sq * sq;
               end
               r.res = acc;
            end
         end
         default: r.res = '0;
      endcase
      return r;
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 5))
         0: return MIN_W;
         1: return MAX_W;
         2: return word_type'($urandom_range(0, 40)) - 20;
         default: return $urandom;
      endcase
   endfunction

   task automatic issue(logic [2:0] op, word_type a, word_type b);
      start <= 1'b1;
      req_type <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (busy);
      pending.push_back(alu_answer(op, a, b));
      sent++;
   endtask

   task automatic add_row(logic [2:0] op, word_type a, word_type b, logic known,
                          word_type res, logic [1:0] err);
      row_type r;
      r = '{op, a, b, known, res, err};
      directed.push_back(r);
   endtask

   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending.size() == 0) begin
            $display("%0t: result %h/%0d with nothing expected", $time, rsp_result,
                     rsp_error_code);
            errors++;
         end else begin
            e = pending.pop_front();
            if (rsp_result !== e.res) begin
               $display("%0t: result expected %h actual %h", $time, e.res, rsp_result);
               errors++;
            end
            if (rsp_error_code !== e.err) begin
               $display("%0t: error_code expected %0d actual %0d", $time, e.err,
                        rsp_error_code);
               errors++;
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("FAIL integer_alu_mul_div_pow_rem");
      $finish;
   end

   initial begin
      int burst;
      int waited;
      logic [2:0] op;
      word_type a;
      word_type b;
      answer_type p;
      errors = 0;
      results_seen = 0;
      sent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_type = OP_ADD;
      req_operand_a = '0;
      req_operand_b = '0;

      add_row(OP_ADD, MAX_W, 1, 1, MIN_W, ERR_NONE);
      add_row(OP_ADD, ONES, ONES, 1, 32'hffff_fffe, ERR_NONE);
      add_row(OP_SUB, MIN_W, 1, 1, MAX_W, ERR_NONE);
      add_row(OP_SUB, 0, MIN_W, 1, MIN_W, ERR_NONE);
      add_row(OP_MUL, MIN_W, ONES, 1, MIN_W, ERR_NONE);
      add_row(OP_MUL, MAX_W, MAX_W, 0, 0, ERR_NONE);
      add_row(OP_DIV, 7, 0, 1, 0, ERR_DIV_ZERO);
      add_row(OP_DIV, MIN_W, ONES, 1, MIN_W, ERR_NONE);
      add_row(OP_DIV, -7, 2, 1, -3, ERR_NONE);
      add_row(OP_DIV, 7, -2, 1, -3, ERR_NONE);
      add_row(OP_DIV, -7, -2, 1, 3, ERR_NONE);
      add_row(OP_DIV, MAX_W, MIN_W, 1, 0, ERR_NONE);
      add_row(OP_REM, MIN_W, 0, 1, 0, ERR_DIV_ZERO);
      add_row(OP_REM, MIN_W, ONES, 1, 0, ERR_NONE);
      add_row(OP_REM, -7, 2, 1, -1, ERR_NONE);
      add_row(OP_REM, 7, -2, 1, 1, ERR_NONE);
      add_row(OP_POW, 0, 0, 1, 1, ERR_NONE);
      add_row(OP_POW, 3, ONES, 1, 0, ERR_NEG_EXP);
      add_row(OP_POW, 2, 31, 1, MIN_W, ERR_NONE);
      add_row(OP_POW, -1, MAX_W, 1, ONES, ERR_NONE);
      add_row(OP_POW, 3, MAX_W, 0, 0, ERR_NONE);
      add_row(3'd6, MAX_W, ONES, 1, 0, ERR_NONE);
      add_row(3'd7, MIN_W, MIN_W, 1, 0, ERR_NONE);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         p = alu_answer(directed[i].op, directed[i].a, directed[i].b);
         if (directed[i].known && (p.res !== directed[i].res || p.err !== directed[i].err)) begin
            $display("%0t: row %0d expected %h/%0d predicted %h/%0d", $time, i,
                     directed[i].res, directed[i].err, p.res, p.err);
            errors++;
         end
         issue(directed[i].op, directed[i].a, directed[i].b);
         if ($urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
      end

      start <= 1'b0;
      while (pending.size() != 0) @(posedge clock);

      while (sent < 450) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst; k++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            a = rand_word();
            b = rand_word();
            if (op == OP_POW && $urandom_range(0, 3) != 0) b = $urandom_range(0, 40);
            issue(op, a, b);
         end
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end

      start <= 1'b0;
      waited = 0;
      while (pending.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);

      $display("Sent %0d requests over all six operations and unused codes;", sent);
      $display("checked %0d results, including zero divisors and negative exponents.",
               results_seen);
      if (errors == 0 && pending.size() == 0) begin
         $display("PASS integer_alu_mul_div_pow_rem");
      end else begin
         $display("FAIL integer_alu_mul_div_pow_rem");
      end
      $finish;
   end

endmodule

`default_nettype wire
